@@ rtl/core/sstack_pkg.sv @@
package sstack_pkg;

  // Stack depth and the widths that follow from it.
  localparam int DEPTH  = 128;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int WORD_W = 32;
  localparam int FILL_W = 8;

  // Request codes.
  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_POP  = 2'd1;
  localparam logic [1:0] FUNC_SORT = 2'd2;

  // Value reported for a missing word.
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [WORD_W-1:0] push_value;
    logic                     descending;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic signed [WORD_W-1:0] top_value;
    logic                     is_empty;
    logic [FILL_W-1:0]        fill_level;
  } out_item_t;

endpackage

@@ rtl/core/sortable_stack.sv @@
// Bounded LIFO stack of signed 32-bit words with an in-place sort.
// Input channel (in_valid / in_stall / in_data): one request per beat, push,
// pop or sort; code three is a no-op. Output channel (out_valid / out_stall /
// out_data): exactly one result beat per request, in request order, with the
// popped word, the new top word, an empty flag and the fill level.
// A push, a no-op, a sort of at most one word, and a pop that leaves the
// stack empty or finds it empty give their result in the next cycle; a pop
// that leaves words behind first reads the new top (S_TOP_WAIT, S_TOP_LOAD).
// A sort of n words is an insertion sort on the word memory: each inserted
// word is read (S_KEY_WAIT, S_KEY_LOAD), compared with the words below it
// one at a time (S_PREV_WAIT, S_PREV_CMP), each one it moves past being
// shifted up, and written into its place (S_KEY_WRITE); then the new top is
// fetched. The block works on one request at a time and holds in_stall high
// until its result is in the output register; the memory has one read port
// with registered read data and one write port.
// While out_stall is high the result beat holds steady, and a new request
// is not taken until the waiting beat is accepted.
// Reset (rst_n low, synchronous) empties the stack and drops any pending
// result; the word memory itself is not cleared.
module sortable_stack (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sstack_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sstack_pkg::out_item_t out_data
);
  import sstack_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP_WAIT,
    S_TOP_LOAD,
    S_KEY_WAIT,
    S_KEY_LOAD,
    S_PREV_WAIT,
    S_PREV_CMP,
    S_KEY_WRITE
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [WORD_W-1:0] top_r, top_nxt;
  logic signed [WORD_W-1:0] popped_r, popped_nxt;
  logic signed [WORD_W-1:0] key_r, key_nxt;
  logic [ADDR_W-1:0]        i_r, i_nxt;
  logic [ADDR_W-1:0]        j_r, j_nxt;
  logic [ADDR_W-1:0]        rd_addr_r, rd_addr_nxt;
  logic                     desc_r, desc_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic signed [WORD_W-1:0] mem_wdata;

  logic load_out;
  logic in_take;
  logic out_of_order;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign out_of_order = desc_r ? (key_r > rd_data_r) : (rd_data_r > key_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    top_nxt       = top_r;
    popped_nxt    = popped_r;
    key_nxt       = key_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rd_addr_nxt   = rd_addr_r;
    desc_nxt      = desc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = j_r;
    mem_wdata     = key_r;
    load_out      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          popped_nxt = EMPTY_WORD;
          case (in_data.func)
            FUNC_PUSH: begin
              if (count_r < CNT_W'(DEPTH)) begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(count_r);
                mem_wdata = in_data.push_value;
                top_nxt   = in_data.push_value;
                count_nxt = count_r + CNT_W'(1);
              end
              load_out = 1'b1;
            end
            FUNC_POP: begin
              if (count_r == '0) begin
                load_out = 1'b1;
              end else begin
                popped_nxt = top_r;
                count_nxt  = count_r - CNT_W'(1);
                if (count_r == CNT_W'(1)) begin
                  load_out = 1'b1;
                end else begin
                  // The word below the old top becomes the new top.
                  rd_addr_nxt = ADDR_W'(count_r - CNT_W'(2));
                  state_nxt   = S_TOP_WAIT;
                end
              end
            end
            FUNC_SORT: begin
              desc_nxt = in_data.descending;
              if (count_r > CNT_W'(1)) begin
                i_nxt       = ADDR_W'(1);
                rd_addr_nxt = ADDR_W'(1);
                state_nxt   = S_KEY_WAIT;
              end else begin
                load_out = 1'b1;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      S_TOP_WAIT: begin
        state_nxt = S_TOP_LOAD;
      end
      S_TOP_LOAD: begin
        top_nxt   = rd_data_r;
        load_out  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_KEY_WAIT: begin
        state_nxt = S_KEY_LOAD;
      end
      S_KEY_LOAD: begin
        key_nxt     = rd_data_r;
        j_nxt       = i_r;
        rd_addr_nxt = i_r - ADDR_W'(1);
        state_nxt   = S_PREV_WAIT;
      end
      S_PREV_WAIT: begin
        state_nxt = S_PREV_CMP;
      end
      S_PREV_CMP: begin
        if (out_of_order) begin
          // Shift the neighbor up by one and keep walking down.
          mem_we    = 1'b1;
          mem_waddr = j_r;
          mem_wdata = rd_data_r;
          j_nxt     = j_r - ADDR_W'(1);
          if (j_r == ADDR_W'(1)) begin
            state_nxt = S_KEY_WRITE;
          end else begin
            rd_addr_nxt = j_r - ADDR_W'(2);
            state_nxt   = S_PREV_WAIT;
          end
        end else begin
          state_nxt = S_KEY_WRITE;
        end
      end
      S_KEY_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = key_r;
        i_nxt     = i_r + ADDR_W'(1);
        if ((CNT_W'(i_r) + CNT_W'(1)) < count_r) begin
          rd_addr_nxt = i_r + ADDR_W'(1);
          state_nxt   = S_KEY_WAIT;
        end else begin
          rd_addr_nxt = ADDR_W'(count_r - CNT_W'(1));
          state_nxt   = S_TOP_WAIT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.popped_value = popped_nxt;
      out_data_nxt.top_value    = (count_nxt == '0) ? EMPTY_WORD : top_nxt;
      out_data_nxt.is_empty     = (count_nxt == '0);
      out_data_nxt.fill_level   = FILL_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      top_r       <= top_nxt;
      popped_r    <= popped_nxt;
      key_r       <= key_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      rd_addr_r   <= rd_addr_nxt;
      desc_r      <= desc_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  // Word memory: one write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr_r];
  end

endmodule

@@ rtl/core/sstack_chk.sv @@
module sstack_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input sstack_pkg::in_item_t  in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input sstack_pkg::out_item_t out_data
);
  import sstack_pkg::*;

  // A result beat held back by the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // The empty flag and the fill level must agree.
  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_empty == (out_data.fill_level == '0)))
    else $error("empty flag disagrees with fill level");

  // An empty stack has no top word.
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |-> out_data.top_value == EMPTY_WORD)
    else $error("empty stack reports a top word");

  // The fill level never passes the depth.
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.fill_level <= FILL_W'(DEPTH))
    else $error("fill level beyond stack depth");

  // Reset drops any pending result.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat survived reset");

endmodule

bind sortable_stack sstack_chk u_sstack_chk (.*);
